/* hdl/wvs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wvs_pkg
// Shared types and constants for the windowed vote class smoother.
// ----------------------------------------------------------------------------
package wvs_pkg;

	localparam int WINDOW_MAX = 16;
	localparam int CLASS_MAX  = 32;

	localparam int SLOT_W  = $clog2(WINDOW_MAX);
	localparam int CLS_W   = $clog2(CLASS_MAX);
	localparam int ADDR_W  = SLOT_W + CLS_W;
	localparam int CNT_W   = $clog2(WINDOW_MAX + 1);   // window length / vote count
	localparam int NCL_W   = $clog2(CLASS_MAX + 1);    // class count
	localparam int CODE_W  = CLS_W + 1;                // class code with no-winner
	localparam int SCORE_W = 32;
	localparam int SUM_W   = SCORE_W + SLOT_W;
	localparam int TOP_W   = CNT_W + 2;                // holds 4*votes and 3*window

	localparam logic [CODE_W-1:0] NO_WIN = '1;

	// Q16.16 thresholds
	localparam logic signed [SCORE_W-1:0] FRAME_FLOOR = -32'sd65536000;
	localparam logic [SUM_W-1:0]          SUM_STEP    = SUM_W'(6553600);

	// config register indexes
	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_CLASSES = 1'b1;

	localparam logic [CNT_W-1:0] WIN_RST = CNT_W'(15);
	localparam logic [NCL_W-1:0] NCL_RST = NCL_W'(32);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] slot;
		logic [CODE_W-1:0] winner;
	} vote_wr_t;

endpackage : wvs_pkg
`default_nettype wire

/* hdl/windowed_vote_class_smoother.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_vote_class_smoother
// Smooths per-frame class scores over a ring of frames; 3/4 vote check.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tuser: class_index[4:0]; tdata: score[31:0]
// m_axis    out  tdata: winner_class, is_unknown, top_votes, frame_winner
// cfg       in   cfg_index 0 window_length, 1 num_classes
//
// After reset the score ring is cleared, one entry a cycle, all 512 entries,
// with s_tready low. A score item is taken only while idle. The item closing
// a frame starts a walk of the ring over W*N entries (one RAM read per cycle),
// W = window, N = classes. A result held on m_axis stalls the next walk's end.
// ----------------------------------------------------------------------------
module windowed_vote_class_smoother
	import wvs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // score[31:0]
	input  wire logic [7:0]  s_tuser,   // class_index[4:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // winner_class[4:0], is_unknown[5],
	                                    // top_votes[10:6], frame_winner[15:11]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  win_len_q;
	logic [NCL_W-1:0]  num_cls_q;
	logic [CNT_W-1:0]  win;
	logic [NCL_W-1:0]  ncl;

	logic [ADDR_W-1:0] clr_q;
	logic [SLOT_W-1:0] rp_q, rp_eff;
	logic [CNT_W-1:0]  rp_inc;

	logic signed [SCORE_W-1:0] fbs_q;
	logic [CODE_W-1:0]         fbc_q, fbc_new;
	logic [CLS_W-1:0]          fw_q;

	logic [SLOT_W-1:0] s_cnt_q;
	logic [CLS_W-1:0]  c_cnt_q;
	logic              s_last, c_last;

	logic              v_s1, first_s1, last_s1;
	logic [CLS_W-1:0]  cls_s1;

	logic signed [SUM_W-1:0] acc_q, acc_nx, best_q;
	logic [CLS_W-1:0]        bcls_q;
	logic                    found_q;
	logic [CNT_W-1:0]        top_q, votes;
	logic                    unknown;

	logic                    m_valid_q;
	logic [15:0]             m_data_q;

	// fsm outputs
	logic clearing, idle, walking, out_free, load_out;

	logic [CLS_W-1:0]          in_cls;
	logic signed [SCORE_W-1:0] in_score;
	logic                      in_ok, in_close, better;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic signed [SCORE_W-1:0] ram_wdata, ram_rdata;
	vote_wr_t                  vwr;

	assign in_cls   = s_tuser[CLS_W-1:0];
	assign in_score = s_tdata;

	// effective window and class count
	always_comb begin
		if (win_len_q == '0) win = CNT_W'(1);
		else if (win_len_q > CNT_W'(WINDOW_MAX)) win = CNT_W'(WINDOW_MAX);
		else win = win_len_q;
		if (num_cls_q == '0) ncl = NCL_W'(1);
		else if (num_cls_q > NCL_W'(CLASS_MAX)) ncl = NCL_W'(CLASS_MAX);
		else ncl = num_cls_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WIN_RST;
			num_cls_q <= NCL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW:  win_len_q <= cfg_data[CNT_W-1:0];
				CFG_CLASSES: num_cls_q <= cfg_data[NCL_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- state machine ----------------
	assign s_last = ({1'b0, s_cnt_q} + CNT_W'(1)) == win;
	assign c_last = ({1'b0, c_cnt_q} + NCL_W'(1)) == ncl;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:  if (in_close) state_d = ST_WALK;
			ST_WALK:  if (s_last && c_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		clearing = 1'b0;
		idle     = 1'b0;
		walking  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_IDLE:  idle = 1'b1;
			ST_WALK:  walking = 1'b1;
			ST_DRAIN: ;
			ST_FIN:   load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	assign s_tready = idle;

	// ---------------- score intake ----------------
	// a shrunken window wraps the ring position before use
	assign rp_eff   = ({1'b0, rp_q} >= win) ? '0 : rp_q;
	assign rp_inc   = {1'b0, rp_eff} + CNT_W'(1);
	assign in_ok    = s_tvalid && idle && ({1'b0, in_cls} < ncl);
	assign in_close = in_ok && (({1'b0, in_cls} + NCL_W'(1)) == ncl);
	assign better   = in_score > fbs_q;
	assign fbc_new  = better ? {1'b0, in_cls} : fbc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rp_q  <= '0;
			fbs_q <= FRAME_FLOOR;
			fbc_q <= NO_WIN;
		end else begin
			if (clearing) clr_q <= clr_q + ADDR_W'(1);
			if (in_close) begin
				rp_q  <= (rp_inc == win) ? '0 : rp_inc[SLOT_W-1:0];
				fbs_q <= FRAME_FLOOR;
				fbc_q <= NO_WIN;
			end else if (in_ok) begin
				rp_q <= rp_eff;
				if (better) begin
					fbs_q <= in_score;
					fbc_q <= {1'b0, in_cls};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_close) fw_q <= (fbc_new == NO_WIN) ? '0 : fbc_new[CLS_W-1:0];
	end

	always_comb begin
		ram_we    = clearing || in_ok;
		ram_waddr = clearing ? clr_q : {rp_eff, in_cls};
		ram_wdata = clearing ? '0 : in_score;
		vwr.we     = in_close;
		vwr.slot   = rp_eff;
		vwr.winner = fbc_new;
	end

	wvs_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr ({s_cnt_q, c_cnt_q}),
		.rdata (ram_rdata)
	);

	wvs_vote u_vote (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (vwr),
		.win    (win),
		.cls    (c_cnt_q),
		.votes  (votes)
	);

	// ---------------- window walk ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_cnt_q <= '0;
			c_cnt_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= walking;
			if (in_close) begin
				s_cnt_q <= '0;
				c_cnt_q <= '0;
			end else if (walking) begin
				if (s_last) begin
					s_cnt_q <= '0;
					c_cnt_q <= c_cnt_q + CLS_W'(1);
				end else begin
					s_cnt_q <= s_cnt_q + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (s_cnt_q == '0);
		last_s1  <= s_last;
		cls_s1   <= c_cnt_q;
	end

	assign acc_nx = (first_s1 ? '0 : acc_q) + SUM_W'(ram_rdata);

	always_ff @(posedge clk) begin
		if (in_close) begin
			best_q  <= '0 - (SUM_W'(win) * SUM_STEP);
			found_q <= 1'b0;
			top_q   <= '0;
		end else begin
			if (v_s1) begin
				acc_q <= acc_nx;
				if (last_s1 && (acc_nx > best_q)) begin
					best_q  <= acc_nx;
					bcls_q  <= cls_s1;
					found_q <= 1'b1;
				end
			end
			// slot winners stay put during the walk; count once per class
			if (walking && (s_cnt_q == '0) && (votes > top_q)) top_q <= votes;
		end
	end

	// ---------------- result register ----------------
	assign unknown = !found_q || ((TOP_W'(top_q) << 2) < (TOP_W'(win) * TOP_W'(3)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {fw_q, top_q, unknown, unknown ? CLS_W'(0) : bcls_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule : windowed_vote_class_smoother
`default_nettype wire

/* hdl/wvs_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wvs_ram
// Score ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wvs_ram
	import wvs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [ADDR_W-1:0]         waddr,
	input  wire logic signed [SCORE_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0]         raddr,
	output logic signed [SCORE_W-1:0]      rdata
);

	logic signed [SCORE_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule : wvs_ram
`default_nettype wire

/* hdl/wvs_vote.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wvs_vote
// Per-slot frame winners and the vote count of one class over the window.
// ----------------------------------------------------------------------------
module wvs_vote
	import wvs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire vote_wr_t         wr,
	input  wire logic [CNT_W-1:0] win,
	input  wire logic [CLS_W-1:0] cls,
	output logic [CNT_W-1:0]      votes
);

	logic [CODE_W-1:0] slot_q [WINDOW_MAX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_MAX; i++) slot_q[i] <= NO_WIN;
		end else if (wr.we) begin
			slot_q[wr.slot] <= wr.winner;
		end
	end

	always_comb begin
		votes = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if ((CNT_W'(i) < win) && (slot_q[i] == {1'b0, cls})) begin
				votes = votes + CNT_W'(1);
			end
		end
	end

endmodule : wvs_vote
`default_nettype wire

/* dv/vote_smoother_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vote_smoother_checker
// Watches the score, result and register channels of the class smoother,
// keeps its own copy of the score ring and vote slots, predicts each result
// and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module vote_smoother_checker
	import wvs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,   // score[31:0]
	input  wire logic [7:0]  s_tuser,   // class_index[4:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,   // winner_class[4:0], is_unknown[5],
	                                    // top_votes[10:6], frame_winner[15:11]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data,
	output int               fail_count,
	output int               pending
);

	// laid out to match m_tdata, highest field first
	typedef struct packed {
		logic [4:0] frame_winner;
		logic [4:0] top_votes;
		logic       is_unknown;
		logic [4:0] winner_class;
	} vote_result_t;

	localparam longint SUM_FLOOR_Q = -64'sd6553600;   // -100 in Q16.16, per frame

	logic signed [31:0] ring_scores [WINDOW_MAX][CLASS_MAX];
	logic [CODE_W-1:0]  slot_won [WINDOW_MAX];
	int unsigned        slot_ptr;
	logic signed [31:0] lead_score;
	logic [CODE_W-1:0]  lead_class;
	logic [4:0]         win_reg;
	logic [5:0]         ncl_reg;
	vote_result_t       results_due[$];
	int                 errs;
	vote_result_t       got;
	vote_result_t       want;

	function automatic int unsigned window_now();
		if (win_reg == 0) return 1;
		if (win_reg > WINDOW_MAX) return WINDOW_MAX;
		return win_reg;
	endfunction

	function automatic int unsigned classes_now();
		if (ncl_reg == 0) return 1;
		if (ncl_reg > CLASS_MAX) return CLASS_MAX;
		return ncl_reg;
	endfunction

	task automatic take_score(input logic [CLS_W-1:0] cls, input logic signed [31:0] sc);
		int unsigned  w;
		int unsigned  nc;
		int unsigned  votes;
		int unsigned  most_votes;
		int unsigned  best_cls;
		longint       sum;
		longint       best_sum;
		bit           found;
		bit           unknown;
		vote_result_t r;
		w = window_now();
		nc = classes_now();
		if (cls >= nc) return;
		if (slot_ptr >= w) slot_ptr = 0;
		ring_scores[slot_ptr][cls] = sc;
		if (sc > lead_score) begin
			lead_score = sc;
			lead_class = CODE_W'(cls);
		end
		if (cls != nc - 1) return;

		// frame closes: record the slot winner, then sum and vote over the window
		slot_won[slot_ptr] = lead_class;
		best_sum = SUM_FLOOR_Q * longint'(w);
		best_cls = 0;
		found = 1'b0;
		most_votes = 0;
		for (int c = 0; c < nc; c++) begin
			sum = 0;
			votes = 0;
			for (int s = 0; s < w; s++) begin
				sum += longint'(ring_scores[s][c]);
				if (slot_won[s] == CODE_W'(c)) votes++;
			end
			if (sum > best_sum) begin
				best_sum = sum;
				best_cls = c;
				found = 1'b1;
			end
			if (votes > most_votes) most_votes = votes;
		end
		unknown = !found || (4 * most_votes < 3 * w);
		r.winner_class = unknown ? 5'd0 : best_cls[4:0];
		r.is_unknown   = unknown;
		r.top_votes    = most_votes[4:0];
		r.frame_winner = (lead_class == NO_WIN) ? 5'd0 : lead_class[4:0];
		results_due.insert(results_due.size(), r);

		slot_ptr = (slot_ptr + 1) % w;
		lead_score = FRAME_FLOOR;
		lead_class = NO_WIN;
	endtask

	task automatic clear_state();
		for (int s = 0; s < WINDOW_MAX; s++) begin
			for (int c = 0; c < CLASS_MAX; c++) ring_scores[s][c] = '0;
			slot_won[s] = NO_WIN;
		end
		slot_ptr = 0;
		lead_score = FRAME_FLOOR;
		lead_class = NO_WIN;
		win_reg = 5'd15;
		ncl_reg = 6'd32;
		results_due.delete();
		errs = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result side first: a result never belongs to the item taken at this edge
			if (m_tvalid && m_tready) begin
				got = vote_result_t'(m_tdata);
				if (results_due.size() == 0) begin
					$display("%0t ns: result with nothing expected: expected none, actual %h",
						$time, got);
					errs++;
				end else begin
					want = results_due.pop_front();
					if (got.winner_class !== want.winner_class) begin
						$display("%0t ns: winner_class expected %0d, actual %0d",
							$time, want.winner_class, got.winner_class);
						errs++;
					end
					if (got.is_unknown !== want.is_unknown) begin
						$display("%0t ns: is_unknown expected %0d, actual %0d",
							$time, want.is_unknown, got.is_unknown);
						errs++;
					end
					if (got.top_votes !== want.top_votes) begin
						$display("%0t ns: top_votes expected %0d, actual %0d",
							$time, want.top_votes, got.top_votes);
						errs++;
					end
					if (got.frame_winner !== want.frame_winner) begin
						$display("%0t ns: frame_winner expected %0d, actual %0d",
							$time, want.frame_winner, got.frame_winner);
						errs++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_WINDOW) win_reg = cfg_data[4:0];
				else ncl_reg = cfg_data;
			end
			if (s_tvalid && s_tready) take_score(s_tuser[CLS_W-1:0], s_tdata);
			fail_count <= errs;
			pending <= results_due.size();
		end
	end

endmodule : vote_smoother_checker

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives score frames and register settings into the class smoother under
// changing flow control; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;
	import wvs_pkg::*;

	localparam int HOLD_CYCLES    = 700;
	localparam int DRAIN_CYCLES   = WINDOW_MAX * CLASS_MAX + 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [31:0] SUM_FLOOR_Q = -32'sd6553600;

	typedef enum {
		PACE_FREE,
		PACE_SEND,
		PACE_RECV,
		PACE_BOTH
	} pace_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [7:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_WINDOW;
	logic [5:0]  cfg_data = '0;
	int          fail_count;
	int          pending;

	int          send_pct = 0;
	int          recv_pct = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          quiet = 0;
	int          classes_in_use = 32;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	windowed_vote_class_smoother DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	vote_smoother_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// result side: one long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_FREE: begin
				send_pct = 0;
				recv_pct <= 0;
			end
			PACE_SEND: begin
				send_pct = 71;
				recv_pct <= 0;
			end
			PACE_RECV: begin
				send_pct = 0;
				recv_pct <= 71;
			end
			default: begin
				send_pct = 8;
				recv_pct <= 8;
			end
		endcase
	endtask

	// one transfer on the score channel; valid stays up between back-to-back items
	task automatic send_score(input logic [4:0] cls, input logic [31:0] sc);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= sc;
		s_tuser <= {3'b000, cls};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// block idle: all results in, plus room for a walk started by a late frame
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [5:0] win, input logic [5:0] ncl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WINDOW;
		cfg_data <= win;
		@(posedge clk);
		cfg_index <= CFG_CLASSES;
		cfg_data <= ncl;
		@(posedge clk);
		cfg_we <= 1'b0;
		classes_in_use = (ncl == 0) ? 1 : (ncl > CLASS_MAX) ? CLASS_MAX : ncl;
	endtask

	function automatic logic [31:0] pick_score(input int style, input bit favored,
		input logic [31:0] tie);
		int v;
		case (style)
			0: begin
				if (favored) return 32'h4000_0000 | {2'b00, 30'($urandom)};
				return $urandom;
			end
			1: begin
				v = int'($urandom_range(262144000)) - 131072000;   // +-2000
				if (favored) v += 196608000;
				return v;
			end
			2: begin
				// right at the frame floor or the per-frame sum floor
				case ($urandom_range(5))
					0: return FRAME_FLOOR - 1;
					1: return FRAME_FLOOR;
					2: return FRAME_FLOOR + 1;
					3: return SUM_FLOOR_Q - 1;
					4: return SUM_FLOOR_Q;
					default: return SUM_FLOOR_Q + 1;
				endcase
			end
			3: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return tie;
		endcase
	endfunction

	task automatic run_phase(input logic [5:0] win, input logic [5:0] ncl, input pace_t p,
		input int items, input bit hold);
		int          sent;
		int          lead;
		int          style;
		int          len;
		int          c;
		int          roll;
		logic [31:0] tie;
		settle();
		write_config(win, ncl);
		set_pace(p);
		if (hold) hold_req <= 1'b1;
		sent = 0;
		lead = $urandom_range(classes_in_use - 1);
		while (sent < items) begin
			if ($urandom_range(9) == 0) lead = $urandom_range(classes_in_use - 1);
			roll = $urandom_range(99);
			if (roll < 80) begin
				// complete frame in class order
				case ($urandom_range(9))
					0, 1: style = 0;
					2, 3, 4, 5: style = 1;
					6: style = 2;
					7: style = 3;
					default: style = 4;
				endcase
				tie = $urandom;
				for (int k = 0; k < classes_in_use; k++)
					send_score(k[4:0], pick_score(style, k == lead, tie));
				sent += classes_in_use;
			end else if (roll < 92) begin
				// broken frame: classes out of order, may or may not close
				len = $urandom_range(classes_in_use, 1);
				repeat (len) begin
					c = $urandom_range(classes_in_use - 1);
					send_score(c[4:0], pick_score($urandom_range(3), 1'b0, 32'h0));
				end
				sent += len;
			end else begin
				// stray item, often beyond the class count
				c = $urandom_range(31);
				send_score(c[4:0], $urandom);
				if (c < classes_in_use) sent++;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		set_pace(PACE_FREE);

		// reset settings: a sparse frame closed by the top class
		send_score(5'd0, 32'h7FFF_FFFF);
		send_score(5'd31, 32'h8000_0000);
		settle();

		write_config(6'd2, 6'd3);
		// nobody above the frame floor
		send_score(5'd0, 32'h8000_0000);
		send_score(5'd1, FRAME_FLOOR);
		send_score(5'd2, FRAME_FLOOR);
		// full tie: first class wins
		send_score(5'd0, 32'd5);
		send_score(5'd1, 32'd5);
		send_score(5'd2, 32'd5);
		// beyond the class count, ignored
		send_score(5'd31, 32'h7FFF_FFFF);
		send_score(5'd3, 32'h0);
		// out of order
		send_score(5'd1, 32'h7FFF_FFFF);
		send_score(5'd0, 32'd1);
		send_score(5'd2, FRAME_FLOOR + 1);
		// lone closing item
		send_score(5'd2, 32'h7FFF_FFFF);
		settle();

		// register zero acts as one (window write 0x20 keeps only zero)
		write_config(6'h20, 6'd0);
		send_score(5'd0, SUM_FLOOR_Q);
		send_score(5'd0, SUM_FLOOR_Q + 1);
		send_score(5'd0, 32'h8000_0000);

		run_phase(6'd16, 6'd4, PACE_FREE, 200, 1'b0);
		run_phase(6'd1, 6'd1, PACE_SEND, 150, 1'b0);
		run_phase(6'h3F, 6'h3F, PACE_RECV, 100, 1'b0);
		run_phase(6'd5, 6'd8, PACE_BOTH, 200, 1'b1);
		run_phase(6'd3, 6'd33, PACE_SEND, 160, 1'b0);
		run_phase(6'd12, 6'd6, PACE_RECV, 200, 1'b0);
		// shrink, then grow back over stale slots
		run_phase(6'd7, 6'd2, PACE_FREE, 150, 1'b0);
		run_phase(6'd16, 6'd5, PACE_BOTH, 200, 1'b0);
		run_phase(6'd10, 6'd3, PACE_SEND, 200, 1'b0);
		run_phase(6'h20, 6'd0, PACE_RECV, 60, 1'b0);
		settle();

		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule : tb_top
